[src/hkst_pkg.sv]
// shared constants, codes and controller/datapath interface types
package hkst_pkg;

   localparam int unsigned CAPACITY_DEF    = 4096;
   localparam int unsigned HANDLE_BITS_DEF = 32;

   localparam logic [63:0] DJB_SEED         = 64'd5381;
   localparam logic [7:0]  MAX_KEY_RESET    = 8'd32;
   localparam logic [15:0] MAX_VALUE_RESET  = 16'd2048;
   localparam logic [12:0] THRESHOLD_RESET  = 13'd1000;

   localparam int unsigned HASH_W    = 64;
   localparam int unsigned KEYLEN_W  = 8;
   localparam int unsigned MAXKEY_W  = 8;
   localparam int unsigned MAXVAL_W  = 16;
   localparam int unsigned THRESH_W  = 13;
   localparam int unsigned POS_W     = 12;
   localparam int unsigned FOUND_W   = 32;
   localparam int unsigned STATUS_W  = 3;
   localparam int unsigned CSR_IDX_W = 2;
   localparam int unsigned CSR_W     = 16;
   localparam int unsigned REQ_W     = 56;
   localparam int unsigned RSP_W     = 112;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MAX_KEY   = 2'd0,
      CSR_MAX_VALUE = 2'd1,
      CSR_THRESHOLD = 2'd2
   } csr_index_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 3'd0,
      ST_NOT_FOUND = 3'd1,
      ST_DUPLICATE = 3'd2,
      ST_FULL      = 3'd3,
      ST_KEY_LONG  = 3'd4,
      ST_VALUE_LONG = 3'd5
   } status_type;

   // datapath operations issued by the controller
   typedef enum logic [3:0] {
      OP_NONE,
      OP_BEAT,
      OP_LAST,
      OP_SCAN_INIT,
      OP_SCAN_RD,
      OP_SCAN_CMP,
      OP_INSERT,
      OP_SORT_RD0,
      OP_SORT_LOAD,
      OP_SORT_RD,
      OP_SORT_CMP,
      OP_SORT_END,
      OP_SORT_DONE,
      OP_RESULT
   } dp_op_type;

   typedef struct packed {
      logic count_zero;
      logic idx_zero;
      logic scan_match;
      logic insert_ok;
      logic do_resort;
      logic sort_last;
      logic swapped;
      logic rsp_free;
   } dp_stat_type;

endpackage

[src/hashed_key_sorted_table_top.sv]
// top level of the djb2 hashed key table with sorted lookup
//
//  channel | dir | handshake              | beat contents
//  req     | in  | req_tvalid/req_tready  | key byte, handle, value length; tuser command, empty
//  rsp     | out | rsp_tvalid/rsp_tready  | status, position, found handle, key hash
//  csr     | in  | csr_we                 | limit and resort threshold registers
//
// a key byte beat is hashed as it is taken; a last beat starts a serial scan from the top of the
// table, reading and then comparing one entry at a time
// an insert that triggers a resort runs bubble passes over the single table ram, up to entries
// passes, then rescans to report the new position
// synchronous active-high reset clears counters and control; table contents are undefined
// a pending response may stall on rsp_tready while further key beats, last beats included, are taken
module hashed_key_sorted_table_top #(
   parameter int unsigned CAPACITY    = hkst_pkg::CAPACITY_DEF,
   parameter int unsigned HANDLE_BITS = hkst_pkg::HANDLE_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [hkst_pkg::REQ_W-1:0]     req_tdata,  // key_byte, value_handle, value_length
   input  logic [1:0]                     req_tuser,  // command, key_empty
   input  logic                           req_tlast,  // key_last
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [hkst_pkg::RSP_W-1:0]     rsp_tdata,  // status, position, found_value, key_hash
   input  logic                           csr_we,
   input  logic [hkst_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [hkst_pkg::CSR_W-1:0]     csr_wdata
);

   hkst_pkg::dp_op_type   op;
   hkst_pkg::dp_stat_type stat;

   hkst_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_tvalid),
      .req_last (req_tlast),
      .req_ready(req_tready),
      .stat     (stat),
      .op       (op)
   );

   hkst_datapath #(
      .CAPACITY   (CAPACITY),
      .HANDLE_BITS(HANDLE_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .op        (op),
      .stat      (stat),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .in_command(req_tuser[0]),
      .in_empty  (req_tuser[1]),
      .in_data   (req_tdata),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_data  (rsp_tdata)
   );

endmodule

[src/hkst_ram.sv]
// generic single write port ram with registered read
module hkst_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

[src/hkst_datapath.sv]
// hashing, table storage, scan and sort datapath, result register
module hkst_datapath #(
   parameter int unsigned CAPACITY    = hkst_pkg::CAPACITY_DEF,
   parameter int unsigned HANDLE_BITS = hkst_pkg::HANDLE_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  hkst_pkg::dp_op_type           op,
   output hkst_pkg::dp_stat_type         stat,
   input  logic                          csr_we,
   input  logic [hkst_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [hkst_pkg::CSR_W-1:0]    csr_wdata,
   input  logic                          in_command,
   input  logic                          in_empty,
   input  logic [hkst_pkg::REQ_W-1:0]    in_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [hkst_pkg::RSP_W-1:0]    rsp_data
);

   localparam int unsigned ADDR_W  = $clog2(CAPACITY);
   localparam int unsigned CNT_W   = $clog2(CAPACITY + 1);
   localparam int unsigned ENTRY_W = hkst_pkg::HASH_W + HANDLE_BITS;
   localparam int unsigned CMP_W   = (CNT_W > hkst_pkg::THRESH_W) ? CNT_W : hkst_pkg::THRESH_W;

   logic [hkst_pkg::MAXKEY_W-1:0] max_key_ff;
   logic [hkst_pkg::MAXVAL_W-1:0] max_val_ff;
   logic [hkst_pkg::THRESH_W-1:0] thresh_ff;

   logic [63:0]                   run_hash_ff, run_hash_in, fin_hash;
   logic [hkst_pkg::KEYLEN_W-1:0] run_len_ff, run_len_in;
   logic [63:0]                   hash_ff;
   logic [hkst_pkg::KEYLEN_W-1:0] klen_ff;
   logic [HANDLE_BITS-1:0]        handle_ff;
   logic [15:0]                   vlen_ff;
   logic                          cmd_ff;

   logic [CNT_W-1:0]  count_ff;
   logic [ADDR_W-1:0] mark_ff;
   logic [ADDR_W-1:0] idx_ff;
   logic [ADDR_W-1:0] pos_ff;
   logic [ADDR_W-1:0] last_idx;
   logic              hit_ff;
   logic              inserted_ff;
   logic [HANDLE_BITS-1:0] hit_handle_ff;
   logic [ENTRY_W-1:0] cur_ff;
   logic              swapped_ff;

   logic              ram_we;
   logic [ADDR_W-1:0] ram_waddr, ram_raddr;
   logic [ENTRY_W-1:0] ram_wdata, ram_rdata;
   logic [63:0]       rd_hash;
   logic              cur_gt;
   logic              full;
   logic [CNT_W-1:0]  diff;

   logic              rsp_valid_ff;
   logic [hkst_pkg::RSP_W-1:0] rsp_data_ff;
   hkst_pkg::status_type res_status;
   logic [ADDR_W-1:0] res_pos;
   logic [HANDLE_BITS-1:0] res_handle;

   // hash update for the current beat
   always_comb begin
      run_hash_in = run_hash_ff;
      run_len_in  = run_len_ff;
      if (!in_empty) begin
         run_hash_in = (run_hash_ff << 5) + run_hash_ff + 64'(in_data[7:0]);
         if (run_len_ff != '1) begin
            run_len_in = run_len_ff + 1'b1;
         end
      end
      fin_hash = (run_len_in == '0) ? 64'd0 : (run_hash_in << 5) + run_hash_in;
   end

   assign rd_hash  = ram_rdata[63:0];
   assign cur_gt   = cur_ff[63:0] > rd_hash;
   assign last_idx = ADDR_W'(count_ff - 1'b1);
   assign full     = count_ff == CNT_W'(CAPACITY);
   assign diff     = count_ff - CNT_W'(mark_ff);

   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = idx_ff;
      ram_wdata = cur_ff;
      ram_raddr = (op == hkst_pkg::OP_SORT_RD0) ? '0 : idx_ff;
      unique case (op)
         hkst_pkg::OP_INSERT: begin
            ram_we    = 1'b1;
            ram_waddr = ADDR_W'(count_ff);
            ram_wdata = {handle_ff, hash_ff};
         end
         hkst_pkg::OP_SORT_CMP: begin
            ram_we    = 1'b1;
            ram_waddr = idx_ff - 1'b1;
            ram_wdata = cur_gt ? ram_rdata : cur_ff;
         end
         hkst_pkg::OP_SORT_END: begin
            ram_we = 1'b1;
         end
         default: begin
         end
      endcase
   end

   hkst_ram #(
      .WIDTH(ENTRY_W),
      .DEPTH(CAPACITY)
   ) u_table (
      .clock(clock),
      .we   (ram_we),
      .waddr(ram_waddr),
      .wdata(ram_wdata),
      .raddr(ram_raddr),
      .rdata(ram_rdata)
   );

   always_comb begin
      stat.count_zero = count_ff == '0;
      stat.idx_zero   = idx_ff == '0;
      stat.scan_match = rd_hash == hash_ff;
      stat.insert_ok  = cmd_ff && !hit_ff && !full && (vlen_ff < max_val_ff)
                        && (klen_ff < max_key_ff);
      stat.do_resort  = (CMP_W'(thresh_ff) <= CMP_W'(diff)) && (count_ff >= CNT_W'(2));
      stat.sort_last  = idx_ff == last_idx;
      stat.swapped    = swapped_ff;
      stat.rsp_free   = !rsp_valid_ff || rsp_ready;
   end

   always_comb begin
      res_pos    = '0;
      res_handle = '0;
      if (inserted_ff) begin
         res_status = hkst_pkg::ST_OK;
         res_pos    = pos_ff;
      end else if (!cmd_ff) begin
         res_status = hit_ff ? hkst_pkg::ST_OK : hkst_pkg::ST_NOT_FOUND;
         if (hit_ff) begin
            res_pos    = pos_ff;
            res_handle = hit_handle_ff;
         end
      end else if (hit_ff) begin
         res_status = hkst_pkg::ST_DUPLICATE;
         res_pos    = pos_ff;
         res_handle = hit_handle_ff;
      end else if (full) begin
         res_status = hkst_pkg::ST_FULL;
      end else if (vlen_ff >= max_val_ff) begin
         res_status = hkst_pkg::ST_VALUE_LONG;
      end else begin
         res_status = hkst_pkg::ST_KEY_LONG;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_key_ff   <= hkst_pkg::MAX_KEY_RESET;
         max_val_ff   <= hkst_pkg::MAX_VALUE_RESET;
         thresh_ff    <= hkst_pkg::THRESHOLD_RESET;
         run_hash_ff  <= hkst_pkg::DJB_SEED;
         run_len_ff   <= '0;
         count_ff     <= '0;
         mark_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               hkst_pkg::CSR_MAX_KEY:   max_key_ff <= csr_wdata[hkst_pkg::MAXKEY_W-1:0];
               hkst_pkg::CSR_MAX_VALUE: max_val_ff <= csr_wdata;
               hkst_pkg::CSR_THRESHOLD: thresh_ff  <= csr_wdata[hkst_pkg::THRESH_W-1:0];
               default: begin
               end
            endcase
         end
         if (op == hkst_pkg::OP_BEAT) begin
            run_hash_ff <= run_hash_in;
            run_len_ff  <= run_len_in;
         end else if (op == hkst_pkg::OP_LAST) begin
            run_hash_ff <= hkst_pkg::DJB_SEED;
            run_len_ff  <= '0;
         end
         if (op == hkst_pkg::OP_INSERT) begin
            count_ff <= count_ff + 1'b1;
         end
         if (op == hkst_pkg::OP_SORT_DONE) begin
            mark_ff <= last_idx;
         end
         if (op == hkst_pkg::OP_RESULT) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // operands and working registers, no reset needed
   always_ff @(posedge clock) begin
      unique case (op)
         hkst_pkg::OP_LAST: begin
            hash_ff     <= fin_hash;
            klen_ff     <= run_len_in;
            cmd_ff      <= in_command;
            handle_ff   <= HANDLE_BITS'(in_data[39:8]);
            vlen_ff     <= in_data[55:40];
            inserted_ff <= 1'b0;
         end
         hkst_pkg::OP_SCAN_INIT: begin
            hit_ff <= 1'b0;
            idx_ff <= last_idx;
         end
         hkst_pkg::OP_SCAN_CMP: begin
            if (rd_hash == hash_ff) begin
               hit_ff        <= 1'b1;
               pos_ff        <= idx_ff;
               hit_handle_ff <= ram_rdata[ENTRY_W-1:hkst_pkg::HASH_W];
            end else begin
               idx_ff <= idx_ff - 1'b1;
            end
         end
         hkst_pkg::OP_INSERT: begin
            inserted_ff <= 1'b1;
            pos_ff      <= ADDR_W'(count_ff);
         end
         hkst_pkg::OP_SORT_LOAD: begin
            cur_ff     <= ram_rdata;
            idx_ff     <= ADDR_W'(1);
            swapped_ff <= 1'b0;
         end
         hkst_pkg::OP_SORT_CMP: begin
            if (cur_gt) begin
               swapped_ff <= 1'b1;
            end else begin
               cur_ff <= ram_rdata;
            end
            if (idx_ff != last_idx) begin
               idx_ff <= idx_ff + 1'b1;
            end
         end
         hkst_pkg::OP_RESULT: begin
            rsp_data_ff <= {1'b0, hash_ff, hkst_pkg::FOUND_W'(res_handle),
                            hkst_pkg::POS_W'(res_pos), res_status};
         end
         default: begin
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

[src/hkst_ctrl.sv]
// controller state machine sequencing hash, scan, insert and sort
module hkst_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_last,
   output logic                  req_ready,
   input  hkst_pkg::dp_stat_type stat,
   output hkst_pkg::dp_op_type   op
);

   typedef enum logic [3:0] {
      S_IDLE, S_SCAN_INIT, S_SCAN_RD, S_SCAN_CMP, S_DECIDE, S_INSERT, S_CHECK,
      S_SORT_RD0, S_SORT_LOAD, S_SORT_RD, S_SORT_CMP, S_SORT_END, S_SORT_DONE, S_RESULT
   } state_type;

   state_type state_ff, state_in;
   logic      rescan_ff, rescan_in;

   always_comb begin
      state_in  = state_ff;
      rescan_in = rescan_ff;
      op        = hkst_pkg::OP_NONE;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op = req_last ? hkst_pkg::OP_LAST : hkst_pkg::OP_BEAT;
               if (req_last) begin
                  state_in = S_SCAN_INIT;
               end
            end
         end
         S_SCAN_INIT: begin
            op       = hkst_pkg::OP_SCAN_INIT;
            state_in = stat.count_zero ? S_DECIDE : S_SCAN_RD;
         end
         S_SCAN_RD: begin
            op       = hkst_pkg::OP_SCAN_RD;
            state_in = S_SCAN_CMP;
         end
         S_SCAN_CMP: begin
            op = hkst_pkg::OP_SCAN_CMP;
            if (stat.scan_match || stat.idx_zero) begin
               state_in = rescan_ff ? S_RESULT : S_DECIDE;
            end else begin
               state_in = S_SCAN_RD;
            end
         end
         S_DECIDE: begin
            state_in = stat.insert_ok ? S_INSERT : S_RESULT;
         end
         S_INSERT: begin
            op       = hkst_pkg::OP_INSERT;
            state_in = S_CHECK;
         end
         S_CHECK: begin
            state_in = stat.do_resort ? S_SORT_RD0 : S_RESULT;
         end
         S_SORT_RD0: begin
            op       = hkst_pkg::OP_SORT_RD0;
            state_in = S_SORT_LOAD;
         end
         S_SORT_LOAD: begin
            op       = hkst_pkg::OP_SORT_LOAD;
            state_in = S_SORT_RD;
         end
         S_SORT_RD: begin
            op       = hkst_pkg::OP_SORT_RD;
            state_in = S_SORT_CMP;
         end
         S_SORT_CMP: begin
            op       = hkst_pkg::OP_SORT_CMP;
            state_in = stat.sort_last ? S_SORT_END : S_SORT_RD;
         end
         S_SORT_END: begin
            op       = hkst_pkg::OP_SORT_END;
            state_in = stat.swapped ? S_SORT_RD0 : S_SORT_DONE;
         end
         S_SORT_DONE: begin
            op        = hkst_pkg::OP_SORT_DONE;
            rescan_in = 1'b1;
            state_in  = S_SCAN_INIT;
         end
         S_RESULT: begin
            if (stat.rsp_free) begin
               op        = hkst_pkg::OP_RESULT;
               rescan_in = 1'b0;
               state_in  = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         rescan_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         rescan_ff <= rescan_in;
      end
   end

   assign req_ready = state_ff == S_IDLE;

endmodule

[src/hkst_checker.sv]
// port-level checker for the hashed key table, bound to the top level
module hkst_port_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_tvalid,
   input logic                       req_tready,
   input logic                       req_tlast,
   input logic                       rsp_tvalid,
   input logic                       rsp_tready,
   input logic [hkst_pkg::RSP_W-1:0] rsp_tdata
);

   logic fail_code;
   assign fail_code = rsp_tdata[2:0] != hkst_pkg::ST_OK
                      && rsp_tdata[2:0] != hkst_pkg::ST_DUPLICATE;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("response dropped while stalled");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && fail_code |-> rsp_tdata[46:3] == '0)
      else $error("failed operation reports position or handle");

   a_last_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tlast |=> !req_tready)
      else $error("accepted a beat during table operation");

endmodule

bind hashed_key_sorted_table_top hkst_port_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_tvalid(req_tvalid),
   .req_tready(req_tready),
   .req_tlast (req_tlast),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata (rsp_tdata)
);

[dv/hkst_checker.sv]
// checker for the hashed key table: follows the channels, predicts each response and compares
module hkst_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   input  logic                             req_tready,
   input  logic [hkst_pkg::REQ_W-1:0]       req_tdata,
   input  logic [1:0]                       req_tuser,
   input  logic                             req_tlast,
   input  logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   input  logic [hkst_pkg::RSP_W-1:0]       rsp_tdata,
   input  logic                             csr_we,
   input  logic [hkst_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [hkst_pkg::CSR_W-1:0]       csr_wdata,
   output int                               fail_count,
   output int                               pending_count,
   output int                               rsp_seen,
   output int                               insert_ok_seen,
   output int                               resort_seen
);
   timeunit 1ns;
   timeprecision 1ps;

   // field order from the top bit down, status lands in the lowest bits
   typedef struct packed {
      logic [63:0]          key_hash;
      logic [31:0]          found_value;
      logic [11:0]          position;
      hkst_pkg::status_type status;
   } table_rsp_type;

   logic [63:0] tbl_hash [4096];
   logic [31:0] tbl_handle [4096];
   int unsigned entries, sort_mark;
   logic [63:0] run_hash;
   int unsigned key_len;
   logic [7:0]  lim_key;
   logic [15:0] lim_value;
   logic [12:0] resort_at;
   table_rsp_type rsp_expected_q[$];

   function automatic bit find_hash(input logic [63:0] h, output int unsigned pos);
      int unsigned lo, hi, mid;
      pos = 0;
      if (entries == 0) return 0;
      if (sort_mark != 0) begin
         lo = 0;
         hi = (sort_mark < entries) ? sort_mark : entries;
         while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            if (h < tbl_hash[mid]) hi = mid;
            else if (h > tbl_hash[mid]) lo = mid + 1;
            else begin
               pos = mid;
               return 1;
            end
         end
      end
      for (int i = int'(entries); i > 0; i--) begin
         if (tbl_hash[i-1] == h) begin
            pos = unsigned'(i - 1);
            return 1;
         end
      end
      return 0;
   endfunction

   task automatic sort_by_hash();
      logic [63:0] kh;
      logic [31:0] kv;
      int j;
      if (entries < 2) return;
      for (int i = 1; i < int'(entries); i++) begin
         kh = tbl_hash[i];
         kv = tbl_handle[i];
         j = i;
         while (j > 0 && tbl_hash[j-1] > kh) begin
            tbl_hash[j]   = tbl_hash[j-1];
            tbl_handle[j] = tbl_handle[j-1];
            j--;
         end
         tbl_hash[j]   = kh;
         tbl_handle[j] = kv;
      end
      sort_mark = entries - 1;
   endtask

   // one accepted request beat; queues the response it causes, if any
   task automatic table_step(input logic [hkst_pkg::REQ_W-1:0] d, input logic [1:0] u,
                             input logic lst);
      table_rsp_type r;
      logic [63:0] h;
      int unsigned klen, pos;
      bit hit;
      if (!u[1]) begin
         run_hash = run_hash * 64'd33 + {56'd0, d[7:0]};
         if (key_len < 255) key_len++;
      end
      if (!lst) return;
      h = (key_len == 0) ? 64'd0 : run_hash * 64'd33;
      klen = key_len;
      run_hash = hkst_pkg::DJB_SEED;
      key_len = 0;
      hit = find_hash(h, pos);
      r.found_value = '0;
      if (!u[0]) begin
         r.status = hit ? hkst_pkg::ST_OK : hkst_pkg::ST_NOT_FOUND;
         if (hit) r.found_value = tbl_handle[pos];
         else pos = 0;
      end else if (hit) begin
         r.status = hkst_pkg::ST_DUPLICATE;
         r.found_value = tbl_handle[pos];
      end else if (entries >= 4096) begin
         r.status = hkst_pkg::ST_FULL;
         pos = 0;
      end else if (d[55:40] >= lim_value) begin
         r.status = hkst_pkg::ST_VALUE_LONG;
         pos = 0;
      end else if (klen >= lim_key) begin
         r.status = hkst_pkg::ST_KEY_LONG;
         pos = 0;
      end else begin
         tbl_hash[entries]   = h;
         tbl_handle[entries] = d[39:8];
         pos = entries;
         entries++;
         insert_ok_seen++;
         if (resort_at <= entries - sort_mark) begin
            resort_seen++;
            sort_by_hash();
            if (!find_hash(h, pos)) pos = 0;
         end
         r.status = hkst_pkg::ST_OK;
      end
      r.position = pos[11:0];
      r.key_hash = h;
      rsp_expected_q.push_back(r);
   endtask

   always @(posedge clock) begin
      table_rsp_type got, want;
      if (reset) begin
         entries        = 0;
         sort_mark      = 0;
         run_hash       = hkst_pkg::DJB_SEED;
         key_len        = 0;
         lim_key        = hkst_pkg::MAX_KEY_RESET;
         lim_value      = hkst_pkg::MAX_VALUE_RESET;
         resort_at      = hkst_pkg::THRESHOLD_RESET;
         fail_count     = 0;
         rsp_seen       = 0;
         insert_ok_seen = 0;
         resort_seen    = 0;
         rsp_expected_q.delete();
         pending_count  = 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               hkst_pkg::CSR_MAX_KEY:   lim_key   = csr_wdata[7:0];
               hkst_pkg::CSR_MAX_VALUE: lim_value = csr_wdata[15:0];
               hkst_pkg::CSR_THRESHOLD: resort_at = csr_wdata[12:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) table_step(req_tdata, req_tuser, req_tlast);
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[110:0];
            rsp_seen++;
            if (rsp_expected_q.size() == 0) begin
               fail_count++;
               $display("%0t unexpected response %h", $time, got);
            end else begin
               want = rsp_expected_q.pop_front();
               if (got.status !== want.status) begin
                  fail_count++;
                  $display("%0t status expected %0d actual %0d", $time, want.status, got.status);
               end
               if (got.position !== want.position) begin
                  fail_count++;
                  $display("%0t position expected %0d actual %0d",
                           $time, want.position, got.position);
               end
               if (got.found_value !== want.found_value) begin
                  fail_count++;
                  $display("%0t found_value expected %h actual %h",
                           $time, want.found_value, got.found_value);
               end
               if (got.key_hash !== want.key_hash) begin
                  fail_count++;
                  $display("%0t key_hash expected %h actual %h",
                           $time, want.key_hash, got.key_hash);
               end
            end
         end
         pending_count = rsp_expected_q.size();
      end
   end

endmodule

[dv/tb_hashed_key_sorted_table_top.sv]
// testbench top for the hashed key table: stimulus, idling, register phases and verdict
module tb_hashed_key_sorted_table_top;
   timeunit 1ns;
   timeprecision 1ps;

   logic clock, reset;
   logic req_tvalid, req_tready, req_tlast;
   logic [hkst_pkg::REQ_W-1:0] req_tdata;
   logic [1:0] req_tuser;
   logic rsp_tvalid, rsp_tready;
   logic [hkst_pkg::RSP_W-1:0] rsp_tdata;
   logic csr_we;
   hkst_pkg::csr_index_type csr_index;
   logic [hkst_pkg::CSR_W-1:0] csr_wdata;

   int fail_count, pending_count, rsp_seen, insert_ok_seen, resort_seen;

   // idle percentages, changed per phase
   int send_idle_pct, recv_idle_pct;
   int beats_sent;

   // small pool of keys so lookups hit and inserts collide
   int unsigned pool_len [64];
   logic [7:0]  pool_byte [64][8];

   localparam logic LOOKUP = 1'b0;
   localparam logic INSERT = 1'b1;

   hashed_key_sorted_table_top dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   hkst_checker u_checker (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .fail_count(fail_count), .pending_count(pending_count), .rsp_seen(rsp_seen),
      .insert_ok_seen(insert_ok_seen), .resort_seen(resort_seen)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // receiver stalls at random per phase
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // hard stop well above the slowest legal run
   initial begin
      #40ms;
      $display("timeout with %0d responses still expected", pending_count);
      $display("FAIL hashed_key_sorted_table_top");
      $finish;
   end

   // one request beat; valid stays high across back-to-back beats
   task automatic send_beat(input logic cmd, input logic [7:0] kb, input logic empty,
                            input logic lst, input logic [31:0] handle,
                            input logic [15:0] vlen);
      int gap;
      gap = 0;
      if ($urandom_range(99) < send_idle_pct) gap = $urandom_range(1, 6);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {vlen, handle, kb};
      req_tuser  <= {empty, cmd};
      req_tlast  <= lst;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      beats_sent++;
   endtask

   // whole key followed by its operation on the last beat
   task automatic send_key(input logic cmd, input int unsigned len, input logic [7:0] kb [],
                           input logic [31:0] handle, input logic [15:0] vlen);
      for (int i = 0; i < len; i++)
         send_beat(cmd, kb[i], 1'b0, i == len - 1, handle, vlen);
      if (len == 0) send_beat(cmd, 8'($urandom), 1'b1, 1'b1, handle, vlen);
   endtask

   task automatic send_pool_key(input int id, input logic cmd, input logic [15:0] vlen);
      logic [7:0] kb [];
      kb = new[8];
      for (int i = 0; i < 8; i++) kb[i] = pool_byte[id][i];
      send_key(cmd, pool_len[id], kb, $urandom, vlen);
   endtask

   // drain all responses, then let the block settle before a register write
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_csr(input hkst_pkg::csr_index_type idx,
                            input logic [hkst_pkg::CSR_W-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we    <= 1'b0;
      @(posedge clock);
   endtask

   // random traffic: mostly pool keys, some fresh and long keys, some noise beats
   task automatic random_traffic(input int n_beats);
      int stop_at, pick, len;
      logic [7:0] kb [];
      logic cmd;
      logic [15:0] vlen;
      stop_at = beats_sent + n_beats;
      while (beats_sent < stop_at) begin
         pick = $urandom_range(99);
         cmd  = 1'($urandom_range(1));
         vlen = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3000));
         if (pick < 60) begin
            send_pool_key($urandom_range(63), cmd, vlen);
         end else if (pick < 90) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(30, 45) : $urandom_range(0, 8);
            kb = new[len];
            for (int i = 0; i < len; i++) kb[i] = 8'($urandom);
            send_key(cmd, len, kb, $urandom, vlen);
         end else begin
            // empty beats that are not last are ignored, then a key ends with an empty last
            send_beat(cmd, 8'($urandom), 1'b1, 1'b0, $urandom, vlen);
            send_beat(cmd, 8'($urandom), 1'b0, 1'b0, $urandom, vlen);
            send_beat(cmd, 8'($urandom), 1'b1, 1'b1, $urandom, vlen);
         end
         // sender holds off until the table has answered everything
         if ($urandom_range(199) == 0) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
            while (pending_count != 0) @(posedge clock);
         end
      end
   endtask

   initial begin
      logic [7:0] kb [];
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      req_tuser     = '0;
      req_tlast     = 1'b0;
      csr_we        = 1'b0;
      csr_index     = hkst_pkg::CSR_MAX_KEY;
      csr_wdata     = '0;
      send_idle_pct = 13;
      recv_idle_pct = 54;
      beats_sent    = 0;
      for (int k = 0; k < 64; k++) begin
         pool_len[k] = $urandom_range(1, 8);
         for (int i = 0; i < 8; i++) pool_byte[k][i] = 8'($urandom);
      end
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: resort on every insert while the table is tiny
      write_csr(hkst_pkg::CSR_THRESHOLD, 16'd1);
      send_key(LOOKUP, 0, kb, 32'h0, 16'd0);            // empty key, nothing stored
      send_key(INSERT, 0, kb, 32'hffff_ffff, 16'd0);    // empty key stored with hash zero
      send_key(INSERT, 0, kb, 32'h1234_5678, 16'd0);    // duplicate of the empty key
      kb = new[3];
      kb[0] = 8'h00;                                    // zero bytes inside a key
      kb[1] = 8'hff;
      kb[2] = 8'h00;
      send_key(INSERT, 3, kb, 32'hffff_ffff, 16'd2047);
      send_key(LOOKUP, 3, kb, 32'h0, 16'hffff);
      send_key(INSERT, 3, kb, 32'h0, 16'd0);
      kb[0] = 8'hff;
      kb[1] = 8'hff;
      kb[2] = 8'hff;
      send_key(INSERT, 3, kb, 32'h0, 16'd2048);         // value too long
      send_key(INSERT, 3, kb, 32'h0, 16'hffff);
      kb = new[260];
      foreach (kb[i]) kb[i] = 8'($urandom);
      send_key(INSERT, 260, kb, 32'h5555_aaaa, 16'd0);  // key length saturates
      // empty beat after characters ends the key
      send_beat(INSERT, 8'h41, 1'b0, 1'b0, 32'haaaa_5555, 16'd1);
      send_beat(INSERT, 8'h7e, 1'b1, 1'b1, 32'haaaa_5555, 16'd1);
      for (int k = 0; k < 8; k++) send_pool_key(k, INSERT, 16'd5);
      for (int k = 0; k < 8; k++) send_pool_key(k, LOOKUP, 16'd5);
      wait_drained();

      // extremes of the limits
      write_csr(hkst_pkg::CSR_MAX_KEY, 16'd1);
      write_csr(hkst_pkg::CSR_MAX_VALUE, 16'd1);
      write_csr(hkst_pkg::CSR_THRESHOLD, 16'd4096);
      random_traffic(120);
      wait_drained();
      write_csr(hkst_pkg::CSR_MAX_KEY, 16'd255);
      write_csr(hkst_pkg::CSR_MAX_VALUE, 16'd65535);
      write_csr(hkst_pkg::CSR_THRESHOLD, 16'd8191);
      random_traffic(200);
      wait_drained();

      // phase a: sender idles lightly, receiver heavily
      write_csr(hkst_pkg::CSR_MAX_KEY, 16'd32);
      write_csr(hkst_pkg::CSR_MAX_VALUE, 16'd2048);
      write_csr(hkst_pkg::CSR_THRESHOLD, 16'd40);
      random_traffic(400);
      wait_drained();

      // phase b: roles swapped
      send_idle_pct = 54;
      recv_idle_pct = 13;
      write_csr(hkst_pkg::CSR_MAX_KEY, 16'd6);
      write_csr(hkst_pkg::CSR_THRESHOLD, 16'd60);
      random_traffic(400);
      wait_drained();

      // phase c: no idling at all
      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_csr(hkst_pkg::CSR_MAX_KEY, 16'd200);
      write_csr(hkst_pkg::CSR_MAX_VALUE, 16'd40000);
      write_csr(hkst_pkg::CSR_THRESHOLD, 16'd1000);
      random_traffic(280);
      wait_drained();
      repeat (50) @(posedge clock);

      $display("covered %0d request beats, %0d responses, %0d stored entries, %0d resorts",
               beats_sent, rsp_seen, insert_ok_seen, resort_seen);
      $display("limit and threshold extremes exercised under three idling mixes");
      if (fail_count == 0 && pending_count == 0) begin
         $display("PASS hashed_key_sorted_table_top");
      end else begin
         $display("%0d mismatches, %0d responses never seen", fail_count, pending_count);
         $display("FAIL hashed_key_sorted_table_top");
      end
      $finish;
   end
endmodule
